/* rtl/core/dprt_pkg.sv */
// Package for the dosing pump run timer.
// Holds the sizes, codes, reset values and beat structures used by all files.
// No dependencies.
package dprt_pkg;

    localparam int PUMPS     = 2;
    localparam int TIME_BITS = 24;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = 32;
    localparam int ACC_W     = 40;
    localparam int MASK_W    = 2;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [CNT_W-1:0]     CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [ACC_W-1:0]     ACC_MAX  = {ACC_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_ACID_MAX_RUN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_MAX_RUN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACID_MIN_OFF = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_MIN_OFF = 2'd3;

    localparam logic [CFG_W-1:0] MAX_RUN_RST = 24'd10000;
    localparam logic [CFG_W-1:0] MIN_OFF_RST = 24'd5000;

    localparam logic [1:0] LVL_STOP = 2'd0;
    localparam logic [1:0] LVL_MAX  = 2'd1;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_RUN   = 3'd1,
        OP_STOP  = 3'd2,
        OP_LEVEL = 3'd3,
        OP_ESTOP = 3'd4,
        OP_QUERY = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        PH_OFF  = 2'd0,
        PH_ON   = 2'd1,
        PH_COOL = 2'd2,
        PH_ERR  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ARG   = 2'd1,
        ST_STATE = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]  operation;
        logic [1:0]  pump;
        logic [23:0] run_duration;
        logic [1:0]  requested_level;
    } t_cmd;

    typedef struct packed {
        logic [1:0]        status;
        logic [1:0]        reported_phase;
        logic              running;
        logic [CNT_W-1:0]  run_count;
        logic [ACC_W-1:0]  total_run_ms;
        logic [MASK_W-1:0] pump_drive;
        logic [MASK_W-1:0] stopped_mask;
    } t_rsp;

endpackage

/* rtl/core/dprt_cmd_if.sv */
// Command channel of the dosing pump run timer: valid, ready and one request beat.
// Depends on dprt_pkg.
interface dprt_cmd_if import dprt_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [1:0]  pump;
    logic [23:0] run_duration;
    logic [1:0]  requested_level;

    modport source (output valid, operation, pump, run_duration, requested_level,
                    input ready);
    modport sink   (input valid, operation, pump, run_duration, requested_level,
                    output ready);
endinterface

/* rtl/core/dprt_rsp_if.sv */
// Result channel of the dosing pump run timer: valid, ready and one result beat.
// Depends on dprt_pkg.
interface dprt_rsp_if import dprt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [1:0]        reported_phase;
    logic              running;
    logic [CNT_W-1:0]  run_count;
    logic [ACC_W-1:0]  total_run_ms;
    logic [MASK_W-1:0] pump_drive;
    logic [MASK_W-1:0] stopped_mask;

    modport source (output valid, status, reported_phase, running, run_count,
                    total_run_ms, pump_drive, stopped_mask, input ready);
    modport sink   (input valid, status, reported_phase, running, run_count,
                    total_run_ms, pump_drive, stopped_mask, output ready);
endinterface

/* rtl/core/dosing_pump_run_timer_top.sv */
// Top level of the dosing pump run timer: command register, per-pump state and result register.
// Depends on dprt_pkg, dprt_cmd_if and dprt_rsp_if.
//
//   Channel   Direction  Handshake          Beat
//   i_cmd     in         valid / ready      operation, pump, run_duration, requested_level
//   o_rsp     out        valid / ready      status, phase, running, counts, drive, stopped
//   i_cfg_*   in         write enable only  register index, 24-bit data
//
// A command accepted into the command register is resolved once the result register is empty or
// being read, when the pump state and the result register update together.
// One command is accepted per cycle while no stalled result blocks it.
// A stalled result holds in the result register while one more command waits behind it.
// Synchronous active-low reset turns all pumps off, clears counters and loads default limits.
module dosing_pump_run_timer_top import dprt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    dprt_cmd_if.sink             i_cmd,
    dprt_rsp_if.source           o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0] r_acid_max;
    logic [CFG_W-1:0] r_base_max;
    logic [CFG_W-1:0] r_acid_off;
    logic [CFG_W-1:0] r_base_off;

    logic  r_cmd_valid;
    t_cmd  r_cmd;
    logic  r_rsp_valid;
    t_rsp  r_rsp;
    t_rsp  n_rsp;
    logic  fire;

    t_phase               r_phase   [PUMPS];
    logic [TIME_BITS-1:0] r_left    [PUMPS];
    logic [TIME_BITS-1:0] r_elapsed [PUMPS];
    logic [TIME_BITS-1:0] r_cool    [PUMPS];
    logic [CNT_W-1:0]     r_runs    [PUMPS];
    logic [ACC_W-1:0]     r_acc     [PUMPS];

    t_phase               n_phase   [PUMPS];
    logic [TIME_BITS-1:0] n_left    [PUMPS];
    logic [TIME_BITS-1:0] n_elapsed [PUMPS];
    logic [TIME_BITS-1:0] n_cool    [PUMPS];
    logic [CNT_W-1:0]     n_runs    [PUMPS];
    logic [ACC_W-1:0]     n_acc     [PUMPS];

    logic [PUMPS-1:0]     hit;
    logic [PUMPS-1:0]     halt_now;
    logic [PUMPS-1:0]     drive;
    logic [PUMPS-1:0]     stopped;
    logic [TIME_BITS-1:0] el_inc    [PUMPS];
    logic [TIME_BITS-1:0] halt_el   [PUMPS];
    logic [TIME_BITS-1:0] max_of    [PUMPS];
    logic [TIME_BITS-1:0] off_of    [PUMPS];
    logic [ACC_W:0]       acc_sum   [PUMPS];

    logic                 pump_ok;
    t_phase               sel_phase;
    logic [TIME_BITS-1:0] sel_cool;
    logic [TIME_BITS-1:0] sel_max;
    logic [TIME_BITS-1:0] start_dur;
    logic [TIME_BITS-1:0] clamp_dur;
    logic                 want_start;
    logic                 do_start;
    t_status              start_st;
    t_status              status;

    assign fire        = r_cmd_valid && (!r_rsp_valid || o_rsp.ready);
    assign i_cmd.ready = !r_cmd_valid || fire;
    assign pump_ok     = int'(r_cmd.pump) < PUMPS;

    always_comb begin
        sel_phase = PH_OFF;
        sel_cool  = '0;
        sel_max   = '0;
        for (int i = 0; i < PUMPS; i++) begin
            hit[i]    = int'(r_cmd.pump) == i;
            max_of[i] = TIME_BITS'((i == 0) ? r_acid_max : r_base_max);
            off_of[i] = TIME_BITS'((i == 0) ? r_acid_off : r_base_off);
            if (hit[i]) begin
                sel_phase = r_phase[i];
                sel_cool  = r_cool[i];
                sel_max   = max_of[i];
            end
        end
    end

    always_comb begin
        start_dur  = (r_cmd.operation == OP_RUN) ? TIME_BITS'(r_cmd.run_duration) : sel_max;
        clamp_dur  = (start_dur > sel_max) ? sel_max : start_dur;
        want_start = pump_ok && ((r_cmd.operation == OP_RUN)
                     || (r_cmd.operation == OP_LEVEL && r_cmd.requested_level == LVL_MAX));
        if (start_dur == '0) begin
            start_st = ST_ARG;
        end else if (sel_phase == PH_COOL && sel_cool != '0) begin
            start_st = ST_STATE;
        end else if (sel_phase == PH_ON) begin
            start_st = ST_STATE;
        end else begin
            start_st = ST_OK;
        end
        do_start = fire && want_start && start_st == ST_OK;

        status = ST_OK;
        case (r_cmd.operation)
            OP_TICK, OP_ESTOP: begin
                status = ST_OK;
            end
            OP_RUN: begin
                status = pump_ok ? start_st : ST_ARG;
            end
            OP_STOP, OP_QUERY: begin
                status = pump_ok ? ST_OK : ST_ARG;
            end
            OP_LEVEL: begin
                if (!pump_ok) begin
                    status = ST_ARG;
                end else if (r_cmd.requested_level == LVL_STOP) begin
                    status = ST_OK;
                end else if (r_cmd.requested_level == LVL_MAX) begin
                    status = start_st;
                end else begin
                    status = ST_ARG;
                end
            end
            default: begin
                status = ST_ARG;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < PUMPS; i++) begin
            n_phase[i]   = r_phase[i];
            n_left[i]    = r_left[i];
            n_elapsed[i] = r_elapsed[i];
            n_cool[i]    = r_cool[i];
            n_runs[i]    = r_runs[i];
            n_acc[i]     = r_acc[i];
            halt_now[i]  = 1'b0;
            el_inc[i]    = (r_elapsed[i] == TIME_MAX) ? r_elapsed[i]
                           : r_elapsed[i] + TIME_BITS'(1);
            halt_el[i]   = r_elapsed[i];
            if (fire) begin
                case (r_cmd.operation)
                    OP_TICK: begin
                        if (r_phase[i] == PH_ON) begin
                            if (r_left[i] <= TIME_BITS'(1)) begin
                                halt_now[i] = 1'b1;
                                halt_el[i]  = el_inc[i];
                            end else begin
                                n_left[i]    = r_left[i] - TIME_BITS'(1);
                                n_elapsed[i] = el_inc[i];
                            end
                        end else if (r_phase[i] == PH_COOL) begin
                            if (r_cool[i] != '0) begin
                                n_cool[i] = r_cool[i] - TIME_BITS'(1);
                            end
                            if (r_cool[i] <= TIME_BITS'(1)) begin
                                n_phase[i] = PH_OFF;
                            end
                        end
                    end
                    OP_ESTOP: begin
                        halt_now[i] = r_phase[i] == PH_ON;
                    end
                    OP_STOP: begin
                        halt_now[i] = pump_ok && hit[i] && r_phase[i] == PH_ON;
                    end
                    OP_LEVEL: begin
                        halt_now[i] = pump_ok && hit[i] && r_phase[i] == PH_ON
                                      && r_cmd.requested_level == LVL_STOP;
                    end
                    default: begin
                        halt_now[i] = 1'b0;
                    end
                endcase
            end
            if (do_start && hit[i]) begin
                n_phase[i]   = PH_ON;
                n_left[i]    = clamp_dur;
                n_elapsed[i] = '0;
                n_cool[i]    = '0;
            end
            acc_sum[i] = {1'b0, r_acc[i]} + (ACC_W + 1)'(halt_el[i]);
            if (halt_now[i]) begin
                n_runs[i]    = (r_runs[i] == CNT_MAX) ? r_runs[i] : r_runs[i] + CNT_W'(1);
                n_acc[i]     = acc_sum[i][ACC_W] ? ACC_MAX : acc_sum[i][ACC_W-1:0];
                n_left[i]    = '0;
                n_elapsed[i] = '0;
                n_cool[i]    = off_of[i];
                n_phase[i]   = (off_of[i] != '0) ? PH_COOL : PH_OFF;
            end
            drive[i]   = n_phase[i] == PH_ON;
            stopped[i] = halt_now[i];
        end
    end

    always_comb begin
        n_rsp                = '0;
        n_rsp.status         = status;
        n_rsp.reported_phase = PH_ERR;
        for (int i = 0; i < PUMPS; i++) begin
            if (pump_ok && hit[i]) begin
                n_rsp.reported_phase = n_phase[i];
                n_rsp.running        = n_phase[i] == PH_ON;
                n_rsp.run_count      = n_runs[i];
                n_rsp.total_run_ms   = n_acc[i];
            end
        end
        for (int b = 0; b < MASK_W; b++) begin
            if (b < PUMPS) begin
                n_rsp.pump_drive[b]   = drive[b];
                n_rsp.stopped_mask[b] = stopped[b];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acid_max  <= MAX_RUN_RST;
            r_base_max  <= MAX_RUN_RST;
            r_acid_off  <= MIN_OFF_RST;
            r_base_off  <= MIN_OFF_RST;
            r_cmd_valid <= 1'b0;
            r_rsp_valid <= 1'b0;
            for (int i = 0; i < PUMPS; i++) begin
                r_phase[i]   <= PH_OFF;
                r_left[i]    <= '0;
                r_elapsed[i] <= '0;
                r_cool[i]    <= '0;
                r_runs[i]    <= '0;
                r_acc[i]     <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ACID_MAX_RUN: begin
                        r_acid_max <= i_cfg_data;
                    end
                    CFG_BASE_MAX_RUN: begin
                        r_base_max <= i_cfg_data;
                    end
                    CFG_ACID_MIN_OFF: begin
                        r_acid_off <= i_cfg_data;
                    end
                    CFG_BASE_MIN_OFF: begin
                        r_base_off <= i_cfg_data;
                    end
                    default: begin
                        r_base_off <= r_base_off;
                    end
                endcase
            end
            if (i_cmd.valid && i_cmd.ready) begin
                r_cmd_valid <= 1'b1;
            end else if (fire) begin
                r_cmd_valid <= 1'b0;
            end
            if (fire) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            if (fire) begin
                for (int i = 0; i < PUMPS; i++) begin
                    r_phase[i]   <= n_phase[i];
                    r_left[i]    <= n_left[i];
                    r_elapsed[i] <= n_elapsed[i];
                    r_cool[i]    <= n_cool[i];
                    r_runs[i]    <= n_runs[i];
                    r_acc[i]     <= n_acc[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_cmd.operation       <= i_cmd.operation;
            r_cmd.pump            <= i_cmd.pump;
            r_cmd.run_duration    <= i_cmd.run_duration;
            r_cmd.requested_level <= i_cmd.requested_level;
        end
        if (fire) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid          = r_rsp_valid;
    assign o_rsp.status         = r_rsp.status;
    assign o_rsp.reported_phase = r_rsp.reported_phase;
    assign o_rsp.running        = r_rsp.running;
    assign o_rsp.run_count      = r_rsp.run_count;
    assign o_rsp.total_run_ms   = r_rsp.total_run_ms;
    assign o_rsp.pump_drive     = r_rsp.pump_drive;
    assign o_rsp.stopped_mask   = r_rsp.stopped_mask;

    // A pump stopped by a command is never reported as driven by the same beat.
    a_stop_not_driven: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> ((r_rsp.stopped_mask & r_rsp.pump_drive) == '0))
        else $error("stopped pump still driven");

    // Running must agree with the reported phase.
    a_running_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid |-> (r_rsp.running == (r_rsp.reported_phase == PH_ON)))
        else $error("running flag disagrees with phase");

    for (genvar g = 0; g < PUMPS; g++) begin : g_chk
        // A pump in cooldown always has lockout time left.
        a_cool_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_phase[g] == PH_COOL) |-> (r_cool[g] != '0))
            else $error("cooldown without time left");

        // Pump state changes only when a command is resolved.
        a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            !fire |=> ($stable(r_phase[g]) && $stable(r_runs[g]) && $stable(r_acc[g])))
            else $error("pump state changed without a command");
    end

endmodule
